FILE: rtl/mdbe_pkg.sv
`default_nettype none

package mdbe_pkg;

    // Configuration port geometry
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEG_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIG_MASK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = 2'd3;

    // Input transaction modes
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_END   = 2'd2;

    // Field widths
    localparam int INTERVAL_W = 16;
    localparam int PHASE_W    = 17;
    localparam int FRAME_W    = 24;
    localparam int LEVEL_W    = 8;

    // Brightness update constants
    localparam int unsigned K_COUNT_GAIN    = 600;
    localparam int unsigned K_OFFSET        = 30;
    localparam int unsigned FRAME_LEN_RESET = 1000;

    // Quotient bits: eight result bits plus one overflow bit
    localparam int QUOT_W = LEVEL_W + 1;

    // Counter bank control
    typedef struct packed {
        logic clear;
        logic sample;
    } t_cnt_ctrl;

endpackage

`default_nettype wire

FILE: rtl/mdbe_counters.sv
`default_nettype none

module mdbe_counters #(
    parameter int NUM_DIGITS   = 4,
    parameter int NUM_SEGMENTS = 8,
    parameter int COUNT_WIDTH  = 24,
    localparam int CELLS       = NUM_DIGITS * NUM_SEGMENTS,
    localparam int CELL_W      = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire mdbe_pkg::t_cnt_ctrl     i_ctrl,
    input  wire logic [NUM_SEGMENTS-1:0] i_seg_bits,
    input  wire logic [NUM_DIGITS-1:0]   i_dig_bits,
    input  wire logic [CELL_W-1:0]       i_rd_cell,
    output logic      [COUNT_WIDTH-1:0]  o_rd_count
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] r_cnt [CELLS];

    // One saturating on-counter per segment of each digit
    for (genvar d = 0; d < NUM_DIGITS; d++) begin : g_dig
        for (genvar s = 0; s < NUM_SEGMENTS; s++) begin : g_seg
            always_ff @(posedge i_clk) begin
                if (!i_rst_n || i_ctrl.clear) begin
                    r_cnt[d*NUM_SEGMENTS+s] <= '0;
                end else if (i_ctrl.sample && i_dig_bits[d] && i_seg_bits[s] &&
                             r_cnt[d*NUM_SEGMENTS+s] != COUNT_MAX) begin
                    r_cnt[d*NUM_SEGMENTS+s] <= r_cnt[d*NUM_SEGMENTS+s] + 1'b1;
                end
            end
        end
    end

    // Read the counter of the cell under update
    assign o_rd_count = r_cnt[i_rd_cell];

endmodule

`default_nettype wire

FILE: rtl/mdbe_div.sv
`default_nettype none

module mdbe_div #(
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [mdbe_pkg::LEVEL_W-1:0]    i_old,
    input  wire logic [COUNT_WIDTH-1:0]          i_count,
    input  wire logic [mdbe_pkg::FRAME_W-1:0]    i_frame_len,
    output logic                                 o_done,
    output logic      [mdbe_pkg::LEVEL_W-1:0]    o_level
);

    // (old + 30) * F is below 2^33; 600 * count below 2^(COUNT_WIDTH+10)
    localparam int PROD_W = mdbe_pkg::LEVEL_W + 1 + mdbe_pkg::FRAME_W;
    localparam int GAIN_W = COUNT_WIDTH + 10;
    localparam int WIDE_W = (COUNT_WIDTH > mdbe_pkg::FRAME_W) ? COUNT_WIDTH
                                                               : mdbe_pkg::FRAME_W;
    localparam int NUM_W  = WIDE_W + 10;
    localparam int DEN_W  = mdbe_pkg::FRAME_W + mdbe_pkg::QUOT_W + 1;
    localparam int STEP_W = $clog2(mdbe_pkg::QUOT_W + 1);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_SUM  = 2'd1;
    localparam logic [1:0] D_DIV  = 2'd2;
    localparam logic [1:0] D_DONE = 2'd3;

    logic [1:0]                       r_state, n_state;
    logic [STEP_W-1:0]                r_step;
    logic [mdbe_pkg::FRAME_W-1:0]     r_frame;
    logic [PROD_W-1:0]                r_prod;
    logic [GAIN_W-1:0]                r_gain;
    logic [NUM_W-1:0]                 r_rem;
    logic [DEN_W-1:0]                 r_den;
    logic [mdbe_pkg::QUOT_W-1:0]      r_quot;

    logic [mdbe_pkg::LEVEL_W:0]       w_old_ofs;
    logic [NUM_W-1:0]                 w_den_ext;
    logic                             w_ge;
    logic                             w_last_step;

    assign w_old_ofs   = {1'b0, i_old} + (mdbe_pkg::LEVEL_W+1)'(mdbe_pkg::K_OFFSET);
    assign w_den_ext   = NUM_W'(r_den);
    assign w_ge        = (r_rem >= w_den_ext);
    assign w_last_step = (r_step == STEP_W'(mdbe_pkg::QUOT_W - 1));

    // Sequence: products, sum, one compare-subtract per quotient bit
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE: if (i_start) n_state = D_SUM;
            D_SUM:  n_state = D_DIV;
            D_DIV:  if (w_last_step) n_state = D_DONE;
            D_DONE: n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_frame <= i_frame_len;
                    r_prod  <= PROD_W'(w_old_ofs) * PROD_W'(i_frame_len);
                    r_gain  <= GAIN_W'(i_count) * GAIN_W'(mdbe_pkg::K_COUNT_GAIN);
                end
            end
            D_SUM: begin
                r_rem  <= NUM_W'(r_prod) + NUM_W'(r_gain);
                r_den  <= {1'b0, r_frame, {mdbe_pkg::QUOT_W{1'b0}}};
                r_quot <= '0;
                r_step <= '0;
            end
            D_DIV: begin
                if (w_ge) begin
                    r_rem <= r_rem - w_den_ext;
                end
                r_quot <= {r_quot[mdbe_pkg::QUOT_W-2:0], w_ge};
                r_den  <= r_den >> 1;
                r_step <= r_step + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Saturate when the overflow quotient bit is set
    assign o_done  = (r_state == D_DONE);
    assign o_level = r_quot[mdbe_pkg::QUOT_W-1] ? '1 : r_quot[mdbe_pkg::LEVEL_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/mux_display_brightness_estimator_top.sv
// Frame-start and tick transactions: accepted one per cycle, no results.
// Frame end: 32 results, each through load and products, sum, nine divider
// compare-subtract steps, done and output.
// The input side stalls from frame-end acceptance until the last result is taken.
// Reset (i_rst_n low, synchronous): counters, brightness and phase clear,
// masks and interval go to zero, frame length to 1000.
`default_nettype none

module mux_display_brightness_estimator_top #(
    parameter int NUM_DIGITS   = 4,
    parameter int NUM_SEGMENTS = 8,
    parameter int COUNT_WIDTH  = 24,
    localparam int CELLS       = NUM_DIGITS * NUM_SEGMENTS,
    localparam int CELL_W      = (CELLS > 1) ? $clog2(CELLS) : 1,
    localparam int DIG_W       = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1,
    localparam int SEG_W       = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [mdbe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [mdbe_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [mdbe_pkg::MODE_W-1:0]       i_mode,
    input  wire logic [NUM_SEGMENTS-1:0]           i_segment_levels,
    input  wire logic [NUM_DIGITS-1:0]             i_digit_levels,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic      [DIG_W-1:0]                  o_digit_index,
    output logic      [SEG_W-1:0]                  o_segment_index,
    output logic      [mdbe_pkg::LEVEL_W-1:0]      o_brightness,
    output logic                                   o_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                          r_state, n_state;
    logic [NUM_SEGMENTS-1:0]             r_seg_mask;
    logic [NUM_DIGITS-1:0]               r_dig_mask;
    logic [mdbe_pkg::INTERVAL_W-1:0]     r_interval;
    logic [mdbe_pkg::FRAME_W-1:0]        r_frame_len;
    logic [mdbe_pkg::PHASE_W-1:0]        r_phase;
    logic [mdbe_pkg::LEVEL_W-1:0]        r_bright [CELLS];
    logic [CELL_W-1:0]                   r_cell;
    logic [DIG_W-1:0]                    r_dig;
    logic [SEG_W-1:0]                    r_seg;
    logic                                r_out_valid;
    logic [DIG_W-1:0]                    r_out_dig;
    logic [SEG_W-1:0]                    r_out_seg;
    logic [mdbe_pkg::LEVEL_W-1:0]        r_out_level;
    logic                                r_out_last;

    logic                                w_in_acc;
    logic                                w_out_acc;
    logic                                w_tick;
    logic                                w_start;
    logic                                w_end;
    logic                                w_sample_due;
    logic                                w_cell_last;
    logic [mdbe_pkg::FRAME_W-1:0]        w_frame_eff;
    logic [COUNT_WIDTH-1:0]              w_count;
    logic                                w_div_done;
    logic [mdbe_pkg::LEVEL_W-1:0]        w_div_level;
    mdbe_pkg::t_cnt_ctrl                 w_cnt_ctrl;

    assign o_in_stall   = (r_state != S_IDLE);
    assign w_in_acc     = i_in_valid && !o_in_stall;
    assign w_out_acc    = r_out_valid && !i_out_stall;
    assign w_start      = w_in_acc && (i_mode == mdbe_pkg::MODE_START);
    assign w_tick       = w_in_acc && (i_mode == mdbe_pkg::MODE_TICK);
    assign w_end        = w_in_acc && (i_mode == mdbe_pkg::MODE_END);
    assign w_sample_due = (r_phase > {1'b0, r_interval});
    assign w_cell_last  = (r_cell == CELL_W'(CELLS - 1));
    assign w_frame_eff  = (r_frame_len == '0) ? mdbe_pkg::FRAME_W'(1) : r_frame_len;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_mask  <= '0;
            r_dig_mask  <= '0;
            r_interval  <= '0;
            r_frame_len <= mdbe_pkg::FRAME_W'(mdbe_pkg::FRAME_LEN_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mdbe_pkg::REG_SEG_MASK:  r_seg_mask  <= i_cfg_data[NUM_SEGMENTS-1:0];
                mdbe_pkg::REG_DIG_MASK:  r_dig_mask  <= i_cfg_data[NUM_DIGITS-1:0];
                mdbe_pkg::REG_INTERVAL:  r_interval  <= i_cfg_data[mdbe_pkg::INTERVAL_W-1:0];
                mdbe_pkg::REG_FRAME_LEN: r_frame_len <= i_cfg_data[mdbe_pkg::FRAME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sampler phase: sample when past the interval, then restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_start) begin
            r_phase <= {1'b0, r_interval} + 1'b1;
        end else if (w_tick) begin
            r_phase <= w_sample_due ? '0 : r_phase + 1'b1;
        end
    end

    assign w_cnt_ctrl.clear  = w_start;
    assign w_cnt_ctrl.sample = w_tick && w_sample_due;

    mdbe_counters #(
        .NUM_DIGITS   (NUM_DIGITS),
        .NUM_SEGMENTS (NUM_SEGMENTS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_counters (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_cnt_ctrl),
        .i_seg_bits (i_segment_levels & r_seg_mask),
        .i_dig_bits (i_digit_levels & r_dig_mask),
        .i_rd_cell  (r_cell),
        .o_rd_count (w_count)
    );

    mdbe_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_state == S_LOAD),
        .i_old       (r_bright[r_cell]),
        .i_count     (w_count),
        .i_frame_len (w_frame_eff),
        .o_done      (w_div_done),
        .o_level     (w_div_level)
    );

    // Frame-end sequencer: one cell at a time through the divider
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_end) n_state = S_LOAD;
            S_LOAD: n_state = S_CALC;
            S_CALC: if (w_div_done) n_state = S_OUT;
            S_OUT:  if (w_out_acc) n_state = r_out_last ? S_IDLE : S_LOAD;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CALC && w_div_done) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk the cells digit-major
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_end) begin
            r_cell <= '0;
            r_dig  <= '0;
            r_seg  <= '0;
        end else if (r_state == S_OUT && w_out_acc && !r_out_last) begin
            r_cell <= r_cell + 1'b1;
            if (r_seg == SEG_W'(NUM_SEGMENTS - 1)) begin
                r_seg <= '0;
                r_dig <= r_dig + 1'b1;
            end else begin
                r_seg <= r_seg + 1'b1;
            end
        end
    end

    // Store the new level and capture the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CELLS; k++) begin
                r_bright[k] <= '0;
            end
        end else if (r_state == S_CALC && w_div_done) begin
            r_bright[r_cell] <= w_div_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CALC && w_div_done) begin
            r_out_dig   <= r_dig;
            r_out_seg   <= r_seg;
            r_out_level <= w_div_level;
            r_out_last  <= w_cell_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_digit_index   = r_out_dig;
    assign o_segment_index = r_out_seg;
    assign o_brightness    = r_out_level;
    assign o_last          = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/mdbe_checker.sv
`default_nettype none

module mdbe_checker #(
    parameter int NUM_DIGITS   = 4,
    parameter int NUM_SEGMENTS = 8,
    localparam int DIG_W       = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1,
    localparam int SEG_W       = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire logic [mdbe_pkg::MODE_W-1:0]    i_mode,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire logic [DIG_W-1:0]               o_digit_index,
    input wire logic [SEG_W-1:0]               o_segment_index,
    input wire logic [mdbe_pkg::LEVEL_W-1:0]   o_brightness,
    input wire logic                           o_last
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_brightness) && $stable(o_last))
        else $error("stalled result changed");

    // No input transaction while results are pending
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input ready while a result is pending");

    // Frame end blocks the input side
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_mode == mdbe_pkg::MODE_END |=> o_in_stall)
        else $error("frame end did not stall the input");

    // Last result belongs to the last cell and ends the burst
    a_last_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |->
            o_digit_index == DIG_W'(NUM_DIGITS - 1) &&
            o_segment_index == SEG_W'(NUM_SEGMENTS - 1))
        else $error("last flag on wrong cell");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last && !i_out_stall |=> !o_out_valid && !o_in_stall)
        else $error("block busy after last result");

endmodule

bind mux_display_brightness_estimator_top mdbe_checker #(
    .NUM_DIGITS   (NUM_DIGITS),
    .NUM_SEGMENTS (NUM_SEGMENTS)
) u_mdbe_checker (.*);

`default_nettype wire
